@@ sv/pmpsup_pkg.sv @@
// Shared types, widths, register indexes and reset values of the pump supervisor.
package pmpsup_pkg;

    // Default counter widths handed to the top level
    localparam int SHORT_TIMER_BITS_DEF = 16;
    localparam int RUN_TIMER_BITS_DEF   = 32;

    // Register widths
    localparam int DEB_W      = 16;
    localparam int CONF_W     = 16;
    localparam int RUN_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RUN  = 2'd2;

    // Register reset values
    localparam logic [DEB_W-1:0]  DEB_RST  = 16'd50;
    localparam logic [CONF_W-1:0] CONF_RST = 16'd5000;
    localparam logic [RUN_W-1:0]  RUN_RST  = 32'd1800000;

    // Beat widths and input bit positions
    localparam int IN_W        = 8;
    localparam int OUT_W       = 8;
    localparam int IN_BUTTON   = 0;
    localparam int IN_FEEDBACK = 1;
    localparam int IN_LVL_ONE  = 2;
    localparam int IN_LVL_TWO  = 3;
    localparam int IN_LVL_THR  = 4;
    localparam int IN_DISP_ON  = 5;
    localparam int IN_DISP_OFF = 6;
    localparam int IN_WAKE     = 7;

    // Debounced levels of one tick
    typedef struct packed {
        logic       btn;   // button pressed
        logic       fb;    // contactor feedback confirmed
        logic [2:0] lvl;   // high-water sensors one to three
    } t_filt;

    // Controller to run timers
    typedef struct packed {
        logic confirm_in;
        logic run_in;
        logic clr;
    } t_tmr_req;

    // Run timers to controller
    typedef struct packed {
        logic confirm;
        logic run;
    } t_tmr_q;

endpackage

@@ sv/pump_supervisor_with_debounce.sv @@
// Top level of the pump supervisor: beat registers, registers, filters, timers, control.
//
//  channel | dir | handshake            | content
//  --------+-----+----------------------+------------------------------------------
//  s       | in  | i_s_tvalid/o_s_tready| one millisecond tick of raw pins (8 bits)
//  m       | out | o_m_tvalid/i_m_tready| pump drive and activity flag (8 bits)
//  cfg     | in  | i_cfg_we             | debounce, confirm timeout, max run time
//
// One tick per clock unless stalled: a beat enters the input register, then the filters,
// timers and control settle in one pass and the result lands in the output register, and
// a new beat is taken every cycle while the output is not blocked. The input register
// refills whenever the output register is empty or being taken. Synchronous active-low
// reset restores the register defaults and all timer state; no clearing pass is needed.
module pump_supervisor_with_debounce import pmpsup_pkg::*; #(
    parameter int SHORT_TIMER_BITS = SHORT_TIMER_BITS_DEF,
    parameter int RUN_TIMER_BITS   = RUN_TIMER_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // [0] button_level [1] feedback_level [2] level_one [3] level_two
    // [4] level_three [5] display_on [6] display_off [7] wake_request
    input  logic [IN_W-1:0]       i_s_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [0] pump_drive [1] activity [7:2] zero
    output logic [OUT_W-1:0]      o_m_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [DEB_W-1:0]  r_deb;
    logic [CONF_W-1:0] r_conf;
    logic [RUN_W-1:0]  r_run;

    logic              r_in_valid;
    logic [IN_W-1:0]   r_in_data;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data;
    logic              w_adv;

    logic [4:0]        w_raw;
    logic [4:0]        w_on_q;
    logic [1:0]        w_off_q;
    t_filt             w_filt;
    t_tmr_req          w_req;
    t_tmr_q            w_tq;
    logic              w_drive;
    logic              w_act;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deb  <= DEB_RST;
            r_conf <= CONF_RST;
            r_run  <= RUN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEBOUNCE: r_deb  <= i_cfg_data[DEB_W-1:0];
                CFG_CONFIRM:  r_conf <= i_cfg_data[CONF_W-1:0];
                CFG_MAX_RUN:  r_run  <= i_cfg_data[RUN_W-1:0];
                default: ;
            endcase
        end
    end

    // beat flow: input register advances into output register
    assign w_adv      = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_data <= i_s_tdata;
        end
        if (w_adv) begin
            r_out_data <= {{(OUT_W - 2){1'b0}}, w_act, w_drive};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // raw pins: 0 feedback, 1 button (pressed low), 2..4 level sensors
    assign w_raw = {r_in_data[IN_LVL_THR], r_in_data[IN_LVL_TWO], r_in_data[IN_LVL_ONE],
                    ~r_in_data[IN_BUTTON], r_in_data[IN_FEEDBACK]};

    // on-delay filters on all five pins
    for (genvar g = 0; g < 5; g++) begin : g_on
        pmpsup_on_delay #(
            .CNT_W (SHORT_TIMER_BITS),
            .PRE_W (DEB_W)
        ) u_on (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_adv    (w_adv),
            .i_in     (w_raw[g]),
            .i_clr    (1'b0),
            .i_preset (r_deb),
            .o_q      (w_on_q[g])
        );
    end

    // off-delay filters behind feedback and button
    for (genvar g = 0; g < 2; g++) begin : g_off
        pmpsup_off_delay #(
            .CNT_W (SHORT_TIMER_BITS),
            .PRE_W (DEB_W)
        ) u_off (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_adv    (w_adv),
            .i_in     (w_on_q[g]),
            .i_preset (r_deb),
            .o_q      (w_off_q[g])
        );
    end

    assign w_filt.btn = w_off_q[1];
    assign w_filt.fb  = w_off_q[0];
    assign w_filt.lvl = w_on_q[4:2];

    // confirm timeout: driven without feedback
    pmpsup_on_delay #(
        .CNT_W (SHORT_TIMER_BITS),
        .PRE_W (CONF_W)
    ) u_confirm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_in     (w_req.confirm_in),
        .i_clr    (w_req.clr),
        .i_preset (r_conf),
        .o_q      (w_tq.confirm)
    );

    // maximum run time: driven with feedback
    pmpsup_on_delay #(
        .CNT_W (RUN_TIMER_BITS),
        .PRE_W (RUN_W)
    ) u_run (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_in     (w_req.run_in),
        .i_clr    (w_req.clr),
        .i_preset (r_run),
        .o_q      (w_tq.run)
    );

    pmpsup_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_filt     (w_filt),
        .i_disp_on  (r_in_data[IN_DISP_ON]),
        .i_disp_off (r_in_data[IN_DISP_OFF]),
        .i_wake     (r_in_data[IN_WAKE]),
        .i_tmr_q    (w_tq),
        .o_tmr_req  (w_req),
        .o_drive    (w_drive),
        .o_activity (w_act)
    );

    // input side only stalls when both stages hold beats and the output is blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_in_valid && r_out_valid && !i_m_tready))
        else $error("input stalled without a full pipeline");

endmodule

@@ sv/pmpsup_on_delay.sv @@
// On-delay timer with saturating counter, also used for the confirm and run timers.
module pmpsup_on_delay import pmpsup_pkg::*; #(
    parameter int CNT_W = SHORT_TIMER_BITS_DEF,
    parameter int PRE_W = DEB_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_in,
    input  logic             i_clr,
    input  logic [PRE_W-1:0] i_preset,
    output logic             o_q
);

    localparam int CMP_W = (CNT_W > PRE_W) ? CNT_W : PRE_W;

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [CNT_W-1:0] w_cnt;

    // count up toward preset while input holds, saturate at all ones
    always_comb begin
        w_cnt = r_cnt;
        if (!i_in) begin
            w_cnt = '0;
        end else if ((CMP_W'(r_cnt) < CMP_W'(i_preset)) && (r_cnt != {CNT_W{1'b1}})) begin
            w_cnt = r_cnt + CNT_W'(1);
        end
    end

    assign o_q   = i_in && (CMP_W'(w_cnt) >= CMP_W'(i_preset));
    assign n_cnt = i_clr ? '0 : w_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_adv) begin
            r_cnt <= n_cnt;
        end
    end

    // a tick with the input low leaves the count empty
    a_low_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && !i_in |=> r_cnt == '0)
        else $error("on-delay count not cleared by low input");

endmodule

@@ sv/pmpsup_off_delay.sv @@
// Off-delay timer: output follows a high input and drops after preset ticks low.
module pmpsup_off_delay import pmpsup_pkg::*; #(
    parameter int CNT_W = SHORT_TIMER_BITS_DEF,
    parameter int PRE_W = DEB_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_in,
    input  logic [PRE_W-1:0] i_preset,
    output logic             o_q
);

    localparam int CMP_W = (CNT_W > PRE_W) ? CNT_W : PRE_W;

    logic [CNT_W-1:0] r_cnt;
    logic             r_q;
    logic [CNT_W-1:0] w_inc;
    logic [CNT_W-1:0] n_cnt;
    logic             n_q;

    // saturating increment of the hold-off count
    always_comb begin
        w_inc = r_cnt;
        if ((CMP_W'(r_cnt) < CMP_W'(i_preset)) && (r_cnt != {CNT_W{1'b1}})) begin
            w_inc = r_cnt + CNT_W'(1);
        end
    end

    // next output and count
    always_comb begin
        n_cnt = r_cnt;
        n_q   = r_q;
        if (i_in) begin
            n_cnt = '0;
            n_q   = 1'b1;
        end else if (r_q) begin
            n_cnt = w_inc;
            n_q   = !(CMP_W'(w_inc) >= CMP_W'(i_preset));
        end
    end

    assign o_q = n_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_q   <= 1'b0;
        end else if (i_adv) begin
            r_cnt <= n_cnt;
            r_q   <= n_q;
        end
    end

endmodule

@@ sv/pmpsup_ctrl.sv @@
// Edge detection on debounced levels and pump drive control.
module pmpsup_ctrl import pmpsup_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_adv,
    input  t_filt    i_filt,
    input  logic     i_disp_on,
    input  logic     i_disp_off,
    input  logic     i_wake,
    input  t_tmr_q   i_tmr_q,
    output t_tmr_req o_tmr_req,
    output logic     o_drive,
    output logic     o_activity
);

    logic [3:0] r_prev;
    logic       r_drive;
    logic       r_first;
    logic       r_wake;

    logic [3:0] w_cur;
    logic [3:0] w_rose;
    logic [3:0] w_fell;
    logic       w_off;
    logic       w_wake;
    logic       w_start;
    logic       n_drive;
    logic       n_wake;
    logic       w_act;

    // edges: bit 0 button, bits 1..3 level sensors
    assign w_cur  = {i_filt.lvl, i_filt.btn};
    assign w_rose = w_cur & ~r_prev;
    assign w_fell = ~w_cur & r_prev;

    // run timers see the drive as it was before this tick
    assign o_tmr_req.confirm_in = r_drive & ~i_filt.fb;
    assign o_tmr_req.run_in     = r_drive & i_filt.fb;
    assign o_tmr_req.clr        = w_off;

    assign w_off = i_disp_off | w_fell[0] | (|w_rose[3:1])
                 | (r_drive & i_tmr_q.confirm) | (r_drive & i_tmr_q.run);
    assign w_wake  = r_wake | i_wake;
    assign w_start = ((i_disp_on | w_rose[0]) & ~r_first) | w_wake;

    // stop wins over start
    always_comb begin
        n_drive = r_drive;
        n_wake  = w_wake;
        w_act   = |(w_rose | w_fell);
        if (w_off) begin
            if (r_drive) begin
                w_act = 1'b1;
            end
            n_drive = 1'b0;
        end else if (w_start && !r_drive) begin
            n_drive = 1'b1;
            n_wake  = 1'b0;
            w_act   = 1'b1;
        end
    end

    assign o_drive    = n_drive;
    assign o_activity = w_act;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_drive <= 1'b0;
            r_first <= 1'b1;
            r_wake  <= 1'b0;
        end else if (i_adv) begin
            r_prev  <= w_cur;
            r_drive <= n_drive;
            r_first <= 1'b0;
            r_wake  <= n_wake;
        end
    end

    // every change of the drive is flagged as activity
    a_change_flagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && (n_drive != r_drive) |-> w_act)
        else $error("drive change without activity");

    // a stop cause always leaves the pump off
    a_stop_wins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && w_off |=> !r_drive)
        else $error("pump running after stop cause");

    // a start clears any pending wake
    a_wake_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && !r_drive && n_drive |=> !r_wake)
        else $error("wake still pending after start");

endmodule

@@ verif/tb_pump_supervisor_with_debounce.sv @@
// Self-checking testbench of the pump supervisor: directed ticks, then randomized tick streams.
`timescale 1ns / 1ps

module tb_pump_supervisor_with_debounce;
    import pmpsup_pkg::*;

    // Input beat, first declared member lands in the top bit
    typedef struct packed {
        logic wake_request;
        logic display_off;
        logic display_on;
        logic level_three;
        logic level_two;
        logic level_one;
        logic feedback_level;
        logic button_level;
    } tick_t;

    // Output beat fields, pump_drive in bit 0
    typedef struct packed {
        logic activity;
        logic pump_drive;
    } pump_result_t;

    // Unused register slot, writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // Timer slots of the predictor
    localparam int TMR_FB      = 0;
    localparam int TMR_BTN     = 1;
    localparam int TMR_CONFIRM = 5;
    localparam int TMR_RUN     = 6;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    // [0] button_level [1] feedback_level [2] level_one [3] level_two
    // [4] level_three [5] display_on [6] display_off [7] wake_request
    logic [IN_W-1:0]       i_s_tdata  = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    // [0] pump_drive [1] activity [7:2] zero
    logic [OUT_W-1:0]      o_m_tdata;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    pump_supervisor_with_debounce dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state
    logic [15:0]  deb_preset;
    logic [15:0]  conf_preset;
    logic [31:0]  run_preset;
    logic [31:0]  tmr_cnt [0:6];
    logic [4:0]   ond_q;
    logic [15:0]  ofd_cnt [0:1];
    logic [1:0]   ofd_q;
    logic [3:0]   edge_prev;
    logic         pump_on;
    logic         fresh_start;
    logic         wake_pend;

    pump_result_t drive_results_due [$];
    int           fail_count     = 0;
    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;

    // Raw pin levels held by the random stream
    logic         btn_pin = 1'b1;
    logic [2:0]   lvl_pins = '0;

    // On-delay step on one timer slot
    function automatic logic on_delay_step(input int k, input logic in_bit,
                                           input logic [31:0] preset);
        if (!in_bit) begin
            tmr_cnt[k] = '0;
            return 1'b0;
        end
        if (tmr_cnt[k] < preset)
            tmr_cnt[k] = tmr_cnt[k] + 32'd1;
        return tmr_cnt[k] >= preset;
    endfunction

    // One millisecond tick: filters, edges, timers, pump control
    function automatic pump_result_t supervise_tick(input tick_t t);
        int           k;
        logic [4:0]   raw;
        logic [3:0]   lvl_now, rose, fell;
        logic         fb_ok, act, lvl_rise, stop, go, conf_q, run_q;
        pump_result_t r;
        if (t.wake_request)
            wake_pend = 1'b1;
        raw = {t.level_three, t.level_two, t.level_one, ~t.button_level, t.feedback_level};
        for (k = 0; k < 5; k++)
            ond_q[k] = on_delay_step(k, raw[k], {16'd0, deb_preset});
        // off-delay stage on feedback and button
        for (k = 0; k < 2; k++) begin
            if (ond_q[k]) begin
                ofd_cnt[k] = '0;
                ofd_q[k]   = 1'b1;
            end else if (ofd_q[k]) begin
                if (ofd_cnt[k] < deb_preset)
                    ofd_cnt[k] = ofd_cnt[k] + 16'd1;
                if (ofd_cnt[k] >= deb_preset)
                    ofd_q[k] = 1'b0;
            end
        end
        // edges: bit 0 button, bits 1..3 level sensors
        lvl_now   = {ond_q[4], ond_q[3], ond_q[2], ofd_q[TMR_BTN]};
        rose      = lvl_now & ~edge_prev;
        fell      = ~lvl_now & edge_prev;
        edge_prev = lvl_now;
        act       = |(rose | fell);
        lvl_rise  = |rose[3:1];
        fb_ok     = ofd_q[TMR_FB];
        conf_q = on_delay_step(TMR_CONFIRM, pump_on & ~fb_ok, {16'd0, conf_preset});
        run_q  = on_delay_step(TMR_RUN, pump_on & fb_ok, run_preset);
        // off wins over on
        stop = t.display_off | fell[0] | lvl_rise | (pump_on & conf_q) | (pump_on & run_q);
        go   = ((t.display_on | rose[0]) & ~fresh_start) | wake_pend;
        if (stop) begin
            if (pump_on)
                act = 1'b1;
            pump_on              = 1'b0;
            tmr_cnt[TMR_CONFIRM] = '0;
            tmr_cnt[TMR_RUN]     = '0;
        end else if (go && !pump_on) begin
            pump_on   = 1'b1;
            wake_pend = 1'b0;
            act       = 1'b1;
        end
        fresh_start  = 1'b0;
        r.pump_drive = pump_on;
        r.activity   = act;
        return r;
    endfunction

    // Receiver side backpressure
    always @(negedge i_clk)
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Result checker
    always @(posedge i_clk) begin : check_results
        pump_result_t got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = pump_result_t'(o_m_tdata[1:0]);
            if (drive_results_due.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected beat, expected none, got %02h", $time, o_m_tdata);
            end else begin
                want = drive_results_due.pop_front();
                if (got.pump_drive !== want.pump_drive) begin
                    fail_count++;
                    $display("%0t: pump_drive mismatch, expected %0b, got %0b",
                             $time, want.pump_drive, got.pump_drive);
                end
                if (got.activity !== want.activity) begin
                    fail_count++;
                    $display("%0t: activity mismatch, expected %0b, got %0b",
                             $time, want.activity, got.activity);
                end
                if (o_m_tdata[OUT_W-1:2] !== '0) begin
                    fail_count++;
                    $display("%0t: pad bits mismatch, expected 0, got %0h",
                             $time, o_m_tdata[OUT_W-1:2]);
                end
            end
        end
    end

    // Send one tick beat; entered and left at a falling edge
    task automatic send_tick(input tick_t t);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= t;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        drive_results_due.push_back(supervise_tick(t));
        @(negedge i_clk);
    endtask

    // Hold off until every result is back, then let the pipeline empty
    task automatic settle_block();
        i_s_tvalid <= 1'b0;
        while (drive_results_due.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Write all registers plus the unused slot; upper data bits of the 16-bit ones carry junk
    task automatic program_regs(input logic [15:0] deb, input logic [15:0] conf,
                                input logic [31:0] run);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_DEBOUNCE;
        i_cfg_data <= {16'($urandom), deb};
        @(negedge i_clk);
        i_cfg_idx  <= CFG_CONFIRM;
        i_cfg_data <= {16'($urandom), conf};
        @(negedge i_clk);
        i_cfg_idx  <= CFG_MAX_RUN;
        i_cfg_data <= run;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_UNUSED;
        i_cfg_data <= $urandom;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        deb_preset  = deb;
        conf_preset = conf;
        run_preset  = run;
    endtask

    // Pins held for stretches, feedback mostly following the pump, some noise
    task automatic drive_random_ticks(input int n);
        tick_t t;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(11) == 0)
                btn_pin = ~btn_pin;
            for (int j = 0; j < 3; j++)
                if ($urandom_range(39) == 0)
                    lvl_pins[j] = ~lvl_pins[j];
            t.button_level   = btn_pin;
            t.feedback_level = ($urandom_range(9) == 0) ? 1'($urandom) : pump_on;
            {t.level_three, t.level_two, t.level_one} = lvl_pins;
            t.display_on   = ($urandom_range(19) == 0);
            t.display_off  = ($urandom_range(29) == 0);
            t.wake_request = ($urandom_range(24) == 0);
            if ($urandom_range(9) == 0)
                t = tick_t'(8'($urandom));
            send_tick(t);
        end
    endtask

    // Reset defaults: first tick, wake latch, start while running, stop while off
    task automatic test_power_up_defaults();
        send_tick(tick_t'(8'b0010_0001));   // display_on ignored on first tick
        send_tick(tick_t'(8'b1111_1111));   // stop blocks wake, wake stays latched
        send_tick(tick_t'(8'b0000_0001));   // latched wake starts the pump
        send_tick(tick_t'(8'b1010_0001));   // start while running
        send_tick(tick_t'(8'b0100_0001));   // stop a running pump
        send_tick(tick_t'(8'b0000_0001));   // wake still pending, restart
        send_tick(tick_t'(8'b0100_0001));
        send_tick(tick_t'(8'b0100_0001));   // stop while off
        send_tick(tick_t'(8'b0000_0000));
    endtask

    // Short presets: button start, confirm timeout, run limit, level stop
    task automatic test_short_timers();
        settle_block();
        program_regs(16'd0, 16'd2, 32'd3);
        send_tick(tick_t'(8'b0000_0001));
        send_tick(tick_t'(8'b0000_0000));   // press starts the pump
        send_tick(tick_t'(8'b0000_0000));
        send_tick(tick_t'(8'b0000_0000));   // no feedback, confirm timeout
        send_tick(tick_t'(8'b0000_0001));   // release while off
        send_tick(tick_t'(8'b0010_0011));
        send_tick(tick_t'(8'b0000_0011));
        send_tick(tick_t'(8'b0000_0011));
        send_tick(tick_t'(8'b0000_0011));   // run limit
        send_tick(tick_t'(8'b0010_0011));
        send_tick(tick_t'(8'b0000_0111));   // high water stops the pump
        send_tick(tick_t'(8'b0000_0011));
    endtask

    // Zero presets pass through; full-scale presets never elapse
    task automatic test_timer_extremes();
        settle_block();
        program_regs(16'd0, 16'd0, 32'd0);
        send_tick(tick_t'(8'b0010_0001));
        send_tick(tick_t'(8'b0000_0001));
        send_tick(tick_t'(8'b0010_0011));
        send_tick(tick_t'(8'b0000_0011));
        settle_block();
        program_regs(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_tick(tick_t'(8'b1000_0000));
        send_tick(tick_t'(8'b0001_1110));
    endtask

    // Random stream under one setting and one idling pattern
    task automatic test_random_traffic(input int n, input int deb_max, input int conf_max,
                                       input int run_max, input int s_pct, input int r_pct);
        settle_block();
        program_regs(16'($urandom_range(deb_max)), 16'($urandom_range(conf_max, 1)),
                     $urandom_range(run_max, 1));
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
        drive_random_ticks(n);
    endtask

    // Short chunks, each with a fresh setting including full-scale ones
    task automatic test_random_reconfig();
        logic [15:0] deb, conf;
        logic [31:0] run;
        for (int c = 0; c < 10; c++) begin
            settle_block();
            deb  = ($urandom_range(4) == 0) ? 16'hFFFF : 16'($urandom_range(6));
            conf = ($urandom_range(5) == 0) ? 16'hFFFF : 16'($urandom_range(15));
            run  = ($urandom_range(5) == 0) ? 32'hFFFF_FFFF : $urandom_range(40);
            program_regs(deb, conf, run);
            case (c % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            drive_random_ticks(38);
        end
    endtask

    initial begin
        // predictor at reset
        deb_preset  = DEB_RST;
        conf_preset = CONF_RST;
        run_preset  = RUN_RST;
        for (int k = 0; k < 7; k++)
            tmr_cnt[k] = '0;
        ofd_cnt[0]  = '0;
        ofd_cnt[1]  = '0;
        ond_q       = '0;
        ofd_q       = '0;
        edge_prev   = '0;
        pump_on     = 1'b0;
        fresh_start = 1'b1;
        wake_pend   = 1'b0;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_power_up_defaults();
        test_short_timers();
        test_timer_extremes();
        test_random_traffic(400, 3, 12, 30, 0, 0);
        test_random_traffic(380, 5, 12, 30, 86, 0);
        test_random_traffic(380, 5, 12, 30, 0, 86);
        test_random_traffic(380, 4, 20, 40, 38, 38);
        test_random_reconfig();

        settle_block();
        repeat (10) @(negedge i_clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
